// ===== rtl/core/gdr_pkg.sv =====
// Shared types and constants of the grid ray caster.
package gdr_pkg;

  localparam int unsigned MAP_BITS  = 6;
  localparam int unsigned MAP_SIDE  = 1 << MAP_BITS;
  localparam int unsigned ADDR_W    = 2 * MAP_BITS;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned VEC_BITS  = 14;
  localparam int unsigned WALK_MAX  = 2 * MAP_SIDE + 1;
  localparam int unsigned DVD_W     = 56;
  localparam int unsigned DVS_W     = 30;

  localparam logic [23:0] DIST_MAX  = 24'hFFFFFF;
  localparam logic [9:0]  COL_MAX   = 10'd1023;
  localparam logic [7:0]  WALL_CODE = 8'd1;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

  // Register indexes
  localparam logic [2:0] CFG_PLAYER_X  = 3'd0;
  localparam logic [2:0] CFG_PLAYER_Y  = 3'd1;
  localparam logic [2:0] CFG_DIR_X     = 3'd2;
  localparam logic [2:0] CFG_DIR_Y     = 3'd3;
  localparam logic [2:0] CFG_PLANE_X   = 3'd4;
  localparam logic [2:0] CFG_PLANE_Y   = 3'd5;
  localparam logic [2:0] CFG_SCREEN_W  = 3'd6;
  localparam logic [2:0] CFG_TEXTURE_W = 3'd7;

  typedef struct packed {
    logic               kind;
    logic [11:0]        column;
    logic [MAP_BITS-1:0] cell_x;
    logic [MAP_BITS-1:0] cell_y;
    logic [7:0]         cell_value;
  } item_t;

  typedef struct packed {
    logic [21:0]        player_x;
    logic [21:0]        player_y;
    logic signed [15:0] view_dir_x;
    logic signed [15:0] view_dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
    logic [12:0]        screen_width;
    logic [10:0]        texture_width;
  } cfg_t;

endpackage

// ===== rtl/core/gdr_div.sv =====
// Restoring divider, one quotient bit per cycle.
module gdr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [gdr_pkg::DVD_W-1:0]   dividend_i,
  input  logic [gdr_pkg::DVS_W-1:0]   divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [gdr_pkg::DVD_W-1:0]   quot_o,
  output logic [gdr_pkg::DVS_W-1:0]   rem_o
);
  import gdr_pkg::*;

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q, rem_q, rem_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DVS_W:0]   rem_sh;

  // Shift in one dividend bit, subtract where it fits
  always_comb begin
    rem_sh = {rem_q, dvd_q[DVD_W-1]};
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = DVS_W'(rem_sh - {1'b0, dvs_q});
        dvd_d = {dvd_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DVS_W-1:0];
        dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start_i && !busy_q) begin
      dvs_q <= divisor_i;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/gdr_front.sv =====
// Request intake: unpacks input requests into a two-entry queue.
module gdr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            in_kind_i,
  input  logic [31:0]     in_data_i,
  input  logic            open_i,
  output logic            q_valid_o,
  output gdr_pkg::item_t  q_item_o,
  input  logic            q_pop_i
);
  import gdr_pkg::*;

  item_t      fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  item_t      item;

  // Unpack request fields
  always_comb begin
    item.kind       = in_kind_i;
    item.column     = in_data_i[11:0];
    item.cell_x     = in_data_i[17:12];
    item.cell_y     = in_data_i[23:18];
    item.cell_value = in_data_i[31:24];
  end

  assign in_ready_o = open_i && (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_item_o   = fifo_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  // Store request payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

endmodule

// ===== rtl/core/gdr_back.sv =====
// Execution side: map store, ray set-up, DDA walk and result register.
module gdr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gdr_pkg::cfg_t   cfg_i,
  input  logic            q_valid_i,
  input  gdr_pkg::item_t  q_item_i,
  output logic            q_pop_o,
  output logic            open_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [55:0]     out_data_o,
  output logic            out_found_o
);
  import gdr_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_CAM   = 5'd1;
  localparam logic [4:0] ST_RX    = 5'd2;
  localparam logic [4:0] ST_RY    = 5'd3;
  localparam logic [4:0] ST_RYF   = 5'd4;
  localparam logic [4:0] ST_SETUP = 5'd5;
  localparam logic [4:0] ST_PA    = 5'd6;
  localparam logic [4:0] ST_PB    = 5'd7;
  localparam logic [4:0] ST_STEP  = 5'd8;
  localparam logic [4:0] ST_TEST  = 5'd9;
  localparam logic [4:0] ST_FD    = 5'd10;
  localparam logic [4:0] ST_FDW   = 5'd11;
  localparam logic [4:0] ST_FM    = 5'd12;
  localparam logic [4:0] ST_FW    = 5'd13;
  localparam logic [4:0] ST_FWW   = 5'd14;
  localparam logic [4:0] ST_COL   = 5'd15;
  localparam logic [4:0] ST_OUT   = 5'd16;

  localparam logic [23:0] ONE = 24'(1) << FRAC_BITS;

  logic [7:0]          mem_q [MAP_SIDE*MAP_SIDE];
  logic [7:0]          rdata_q;
  logic [ADDR_W:0]     clr_q;
  logic                clr_done;

  logic [4:0]          st_q;
  logic signed [28:0]  cam_q;
  logic signed [44:0]  prod_q, prod_sh;
  logic signed [30:0]  rx_q, ry_q;
  logic [DVS_W-1:0]    ax_q, ay_q;
  logic                sxn_q, syn_q;
  logic [23:0]         tx_q, ty_q, t_q;
  logic signed [7:0]   mx_q, my_q, mx_n, my_n;
  logic [7:0]          n_q;
  logic [53:0]         pa_q, pb_q, pw_q;
  logic                side_q, found_q, go_x;
  logic [23:0]         dist_q;
  logic [15:0]         frac_q, qq, offl;
  logic [26:0]         colp_q;
  logic                oth_neg;
  logic [DVS_W-1:0]    a_sel, oth_abs;
  logic [15:0]         p_oth;
  logic signed [30:0]  r_oth;

  logic                div_start, div_busy, div_done;
  logic [DVD_W-1:0]    div_dvd, div_q;
  logic [DVS_W-1:0]    div_dvs, div_rem;

  logic                out_valid_q, out_found_q;
  logic [55:0]         out_data_q;
  logic [1:0]          tex_idx;
  logic [9:0]          tex_col;

  gdr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_rem)
  );

  assign clr_done = clr_q[ADDR_W];
  assign open_o   = clr_done;
  assign q_pop_o  = (st_q == ST_IDLE) && q_valid_i && clr_done;
  assign prod_sh  = prod_q >>> VEC_BITS;

  // Pick the axis and side of the finishing divisions
  assign a_sel   = side_q ? ay_q : ax_q;
  assign r_oth   = side_q ? rx_q : ry_q;
  assign p_oth   = side_q ? cfg_i.player_x[15:0] : cfg_i.player_y[15:0];
  assign oth_neg = r_oth[30];
  assign oth_abs = DVS_W'(oth_neg ? -r_oth : r_oth);

  // Step decision by cross multiplication
  always_comb begin
    priority if (ry_q == '0 && rx_q != '0) begin
      go_x = 1'b1;
    end else if (rx_q == '0) begin
      go_x = 1'b0;
    end else begin
      go_x = pa_q < pb_q;
    end
    mx_n = mx_q;
    my_n = my_q;
    if (go_x) begin
      mx_n = 8'(mx_q + (sxn_q ? -8'sd1 : 8'sd1));
    end else begin
      my_n = 8'(my_q + (syn_q ? -8'sd1 : 8'sd1));
    end
  end

  // Divider requests
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    unique case (st_q)
      ST_IDLE: begin
        div_start = q_pop_o && (q_item_i.kind == KIND_CAST);
        div_dvd   = DVD_W'({q_item_i.column, 1'b0, VEC_BITS'(0)});
        div_dvs   = (cfg_i.screen_width == '0) ? DVS_W'(1) : DVS_W'(cfg_i.screen_width);
      end
      ST_FD: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'({t_q, VEC_BITS'(0)});
        div_dvs   = a_sel;
      end
      ST_FW: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(pw_q);
        div_dvs   = a_sel;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Offset of the wall point, floored
  always_comb begin
    qq   = div_q[15:0] + 16'(div_rem != '0 && oth_neg);
    offl = oth_neg ? 16'(-qq) : qq;
  end

  // Result fields
  always_comb begin
    if (side_q) begin
      tex_idx = syn_q ? 2'd2 : 2'd3;
    end else begin
      tex_idx = sxn_q ? 2'd0 : 2'd1;
    end
    tex_col = (colp_q[26] != 1'b0) ? COL_MAX : colp_q[25:16];
  end

  // Clear the map after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (!clr_done) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Map store: clearing pass, cell writes, walk reads
  always_ff @(posedge clk_i) begin
    if (!clr_done) begin
      mem_q[clr_q[ADDR_W-1:0]] <= '0;
    end else if (q_pop_o && q_item_i.kind == KIND_WRITE) begin
      mem_q[{q_item_i.cell_x, q_item_i.cell_y}] <= q_item_i.cell_value;
    end
    if (st_q == ST_STEP) begin
      rdata_q <= mem_q[{mx_n[MAP_BITS-1:0], my_n[MAP_BITS-1:0]}];
    end
  end

  // Hold the result until taken, load a new one when the register is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      unique case (st_q)
        ST_IDLE: begin
          if (q_pop_o && q_item_i.kind == KIND_CAST) begin
            st_q <= ST_CAM;
          end
        end
        ST_CAM:   if (div_done) st_q <= ST_RX;
        ST_RX:    st_q <= ST_RY;
        ST_RY:    st_q <= ST_RYF;
        ST_RYF:   st_q <= ST_SETUP;
        ST_SETUP: st_q <= ST_PA;
        ST_PA:    st_q <= ST_PB;
        ST_PB:    st_q <= ST_STEP;
        ST_STEP:  st_q <= ST_TEST;
        ST_TEST: begin
          if (mx_q[7:MAP_BITS] != '0 || my_q[7:MAP_BITS] != '0) begin
            st_q <= ST_OUT;
          end else if (rdata_q == WALL_CODE) begin
            st_q <= (!side_q || ay_q != '0) ? ST_FD : ST_COL;
          end else if (n_q == 8'(WALK_MAX)) begin
            st_q <= ST_OUT;
          end else begin
            st_q <= ST_PA;
          end
        end
        ST_FD:    st_q <= ST_FDW;
        ST_FDW:   if (div_done) st_q <= ST_FM;
        ST_FM:    st_q <= ST_FW;
        ST_FW:    st_q <= ST_FWW;
        ST_FWW:   if (div_done) st_q <= ST_COL;
        ST_COL:   st_q <= ST_OUT;
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            st_q <= ST_IDLE;
          end
        end
        default:  st_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_CAM: begin
        cam_q <= 29'(signed'({2'b00, div_q[26:0]}) - 29'sd16384);
      end
      ST_RX: prod_q <= cfg_i.plane_x * cam_q;
      ST_RY: begin
        rx_q   <= 31'(cfg_i.view_dir_x) + 31'(prod_sh);
        prod_q <= cfg_i.plane_y * cam_q;
      end
      ST_RYF: ry_q <= 31'(cfg_i.view_dir_y) + 31'(prod_sh);
      ST_SETUP: begin
        ax_q  <= DVS_W'(rx_q[30] ? -rx_q : rx_q);
        ay_q  <= DVS_W'(ry_q[30] ? -ry_q : ry_q);
        sxn_q <= rx_q[30];
        syn_q <= ry_q[30];
        tx_q  <= rx_q[30] ? 24'(cfg_i.player_x[15:0]) : ONE - 24'(cfg_i.player_x[15:0]);
        ty_q  <= ry_q[30] ? 24'(cfg_i.player_y[15:0]) : ONE - 24'(cfg_i.player_y[15:0]);
        mx_q  <= 8'({2'b00, cfg_i.player_x[21:16]});
        my_q  <= 8'({2'b00, cfg_i.player_y[21:16]});
        n_q   <= '0;
        found_q <= 1'b0;
      end
      ST_PA: pa_q <= tx_q * ay_q;
      ST_PB: pb_q <= ty_q * ax_q;
      ST_STEP: begin
        if (go_x) begin
          t_q  <= tx_q;
          tx_q <= tx_q + ONE;
        end else begin
          t_q  <= ty_q;
          ty_q <= ty_q + ONE;
        end
        side_q <= !go_x;
        mx_q   <= mx_n;
        my_q   <= my_n;
        n_q    <= n_q + 8'd1;
      end
      ST_TEST: begin
        if (mx_q[7:MAP_BITS] == '0 && my_q[7:MAP_BITS] == '0 && rdata_q == WALL_CODE) begin
          found_q <= 1'b1;
          dist_q  <= DIST_MAX;
          frac_q  <= cfg_i.player_x[15:0];
        end
      end
      ST_FDW: begin
        if (div_done) begin
          dist_q <= (div_q[DVD_W-1:24] != '0) ? DIST_MAX : div_q[23:0];
        end
      end
      ST_FM: pw_q <= t_q * oth_abs;
      ST_FWW: begin
        if (div_done) begin
          frac_q <= p_oth + offl;
        end
      end
      ST_COL: colp_q <= frac_q * 16'(cfg_i.texture_width);
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_found_q <= found_q;
          if (found_q) begin
            out_data_q <= {7'b0, my_q[5:0], mx_q[5:0], tex_col, tex_idx, side_q, dist_q};
          end else begin
            out_data_q <= {32'b0, DIST_MAX};
          end
        end
      end
      default: begin
        cam_q <= cam_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_found_o = out_found_q;

  // Queue is only drained once the map is cleared
  a_pop_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> clr_done)
    else $error("item taken during map clear");

  // Divider is never restarted while it runs
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // Walk never exceeds its step bound
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_STEP) |-> (n_q < 8'(WALK_MAX)))
    else $error("walk step count overrun");

  // A result is loaded only when the output register is free or drains
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_OUT && out_valid_q && !out_ready_i) |=> (st_q == ST_OUT))
    else $error("result overwritten");

endmodule

// ===== rtl/core/grid_dda_raycaster.sv =====
// Grid ray caster top level: register file, request queue and walk engine.
// A map write goes straight into the map store. A cast runs the serial divider once
// for the camera position and, on a wall hit, up to twice more for distance and wall
// offset, around a DDA step loop through the PA, PB, STEP and TEST states.
// Results leave one per cast through a single output register.
// rst_ni resets control and loads register defaults, then a pass zeroes all 4096 map cells;
// no request is accepted until that pass ends.
module grid_dda_raycaster (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // column, cell_x, cell_y, cell_value
  input  logic        s_axis_tuser_i,  // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,  // distance, hit_side, texture_index,
                                       // texture_column, hit_x, hit_y
  output logic        m_axis_tuser_o,  // found
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [21:0] cfg_data_i
);
  import gdr_pkg::*;

  cfg_t  cfg_q;
  item_t q_item;
  logic  q_valid, q_pop, open;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.player_x      <= '0;
      cfg_q.player_y      <= '0;
      cfg_q.view_dir_x    <= 16'sd16384;
      cfg_q.view_dir_y    <= '0;
      cfg_q.plane_x       <= '0;
      cfg_q.plane_y       <= 16'sd10813;
      cfg_q.screen_width  <= 13'd640;
      cfg_q.texture_width <= 11'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PLAYER_X:  cfg_q.player_x      <= cfg_data_i;
        CFG_PLAYER_Y:  cfg_q.player_y      <= cfg_data_i;
        CFG_DIR_X:     cfg_q.view_dir_x    <= cfg_data_i[15:0];
        CFG_DIR_Y:     cfg_q.view_dir_y    <= cfg_data_i[15:0];
        CFG_PLANE_X:   cfg_q.plane_x       <= cfg_data_i[15:0];
        CFG_PLANE_Y:   cfg_q.plane_y       <= cfg_data_i[15:0];
        CFG_SCREEN_W:  cfg_q.screen_width  <= cfg_data_i[12:0];
        CFG_TEXTURE_W: cfg_q.texture_width <= cfg_data_i[10:0];
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  gdr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_kind_i  (s_axis_tuser_i),
    .in_data_i  (s_axis_tdata_i),
    .open_i     (open),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  gdr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .open_o      (open),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_found_o (m_axis_tuser_o)
  );

endmodule
